/* rtl/vsc_pkg.sv */
// Package for the version string compare block: parse phase type,
// character codes and the status struct between parser and comparator.
// No dependencies.
package vsc_pkg;

  // Parse phase, one-hot
  typedef enum logic [8:0] {
    PH_START     = 9'b000000001,
    PH_MAJ_FIRST = 9'b000000010,
    PH_MAJ       = 9'b000000100,
    PH_MIN_FIRST = 9'b000001000,
    PH_MIN       = 9'b000010000,
    PH_PAT_FIRST = 9'b000100000,
    PH_PAT       = 9'b001000000,
    PH_DONE      = 9'b010000000,
    PH_BAD       = 9'b100000000
  } phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_V = 8'h76;
  localparam logic [7:0] CH_UP_V  = 8'h56;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic FUNC_REF  = 1'b0;
  localparam logic FUNC_CAND = 1'b1;

  // End-of-string status from parser to comparator
  typedef struct packed {
    logic ref_end;   // NUL of a reference string taken this cycle
    logic cand_end;  // NUL of a candidate string taken this cycle
    logic valid;     // string parsed as a valid version
    logic pre;       // valid and carries a prerelease suffix
  } parse_stat_t;

endpackage

/* rtl/version_string_compare.sv */
// Version string compare, top level: input register, parser, reference
// compare and result register. A beat is parsed from the input register; a
// candidate NUL there loads its result into the result register on out_*.
// Throughput: one character beat per cycle, limited by the parse step (one
// times-ten add per cycle on the phase/accumulator loop); a candidate NUL stalls
// while the result register is full. Reset: rst_n synchronous active low; clears
// parse state, drops the held reference and empties both pipeline registers.
module version_string_compare #(
  parameter int unsigned COMPONENT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // character stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic [0:0] in_tuser,   // [0] func: 0 reference, 1 candidate
  // compare results, one per candidate string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] newer, [1] reference_valid,
                                 // [2] candidate_valid, [3] candidate_prerelease,
                                 // [7:4] zero
);
  import vsc_pkg::*;

  logic                      s1_valid_r;
  logic [7:0]                s1_ch_r;
  logic                      s1_func_r;
  logic                      out_valid_r;
  logic [3:0]                out_data_r;
  logic                      emits, out_free, go;
  parse_stat_t               stat;
  logic [COMPONENT_BITS-1:0] major, minor, patch;
  logic [3:0]                result;

  // Only a candidate NUL produces a result beat; every other character is
  // absorbed by the parser and never waits on the output side.
  assign emits     = (s1_ch_r == CH_NUL) && (s1_func_r == FUNC_CAND);
  assign out_free  = !out_valid_r || out_tready;
  assign go        = s1_valid_r && (!emits || out_free);
  assign in_tready = !s1_valid_r || go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r   <= in_tdata;
      s1_func_r <= in_tuser[0];
    end
  end

  vsc_parse #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .func  (s1_func_r),
    .ch    (s1_ch_r),
    .stat  (stat),
    .major (major),
    .minor (minor),
    .patch (patch)
  );

  vsc_ref_cmp #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_ref_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat   (stat),
    .major  (major),
    .minor  (minor),
    .patch  (patch),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.cand_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.cand_end) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};

  // a stalled character stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !go |=> s1_valid_r && $stable(s1_ch_r) && $stable(s1_func_r))
    else $error("input register lost a stalled beat");

  // a result is only loaded when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cand_end |-> out_free)
    else $error("result register overwritten");

  // newer needs both versions valid; prerelease needs a valid candidate
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r[0] || (out_data_r[1] && out_data_r[2]))
                    && (!out_data_r[3] || out_data_r[2]))
    else $error("inconsistent result flags");

endmodule

/* rtl/vsc_parse.sv */
// Character parser: one-hot phase register and major/minor/patch accumulators.
// Depends on vsc_pkg.
module vsc_parse #(
  parameter int unsigned COMPONENT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic                      func,
  input  logic [7:0]                ch,
  output vsc_pkg::parse_stat_t      stat,
  output logic [COMPONENT_BITS-1:0] major,
  output logic [COMPONENT_BITS-1:0] minor,
  output logic [COMPONENT_BITS-1:0] patch
);
  import vsc_pkg::*;

  localparam int unsigned W = COMPONENT_BITS;

  phase_t          phase_r, phase_nxt, eff;
  logic [W-1:0]    major_r, major_nxt;
  logic [W-1:0]    minor_r, minor_nxt;
  logic [W-1:0]    patch_r, patch_nxt;
  logic            pre_r, pre_nxt;
  logic            is_digit, is_nul, valid;
  logic [W-1:0]    acc;
  logic [W+3:0]    acc_x, mul10;
  logic            ovf;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_nul   = (ch == CH_NUL);
  assign valid    = (phase_r == PH_PAT) || (phase_r == PH_DONE);

  // a leading v/V is skipped, anything else parses as the first major char
  assign eff = ((phase_r == PH_START) && (ch != CH_LOW_V) && (ch != CH_UP_V))
               ? PH_MAJ_FIRST : phase_r;

  // one shared times-ten-plus-digit unit; overflow when the top bits are set
  always_comb begin
    case (eff)
      PH_MAJ_FIRST, PH_MAJ: acc = major_r;
      PH_MIN_FIRST, PH_MIN: acc = minor_r;
      default:              acc = patch_r;
    endcase
  end
  assign acc_x = {4'b0000, acc};
  assign mul10 = (acc_x << 3) + (acc_x << 1) + {{W{1'b0}}, ch[3:0]};
  assign ovf   = |mul10[W+3:W];

  always_comb begin
    phase_nxt = phase_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    patch_nxt = patch_r;
    pre_nxt   = pre_r;
    if (is_nul) begin
      phase_nxt = PH_START;
      major_nxt = '0;
      minor_nxt = '0;
      patch_nxt = '0;
      pre_nxt   = 1'b0;
    end else begin
      unique case (eff)
        PH_START: begin
          phase_nxt = PH_MAJ_FIRST;
        end
        PH_MAJ_FIRST, PH_MAJ: begin
          if (is_digit) begin
            phase_nxt = ovf ? PH_BAD : PH_MAJ;
            major_nxt = mul10[W-1:0];
          end else if ((eff == PH_MAJ) && (ch == CH_DOT)) begin
            phase_nxt = PH_MIN_FIRST;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_MIN_FIRST, PH_MIN: begin
          if (is_digit) begin
            phase_nxt = ovf ? PH_BAD : PH_MIN;
            minor_nxt = mul10[W-1:0];
          end else if ((eff == PH_MIN) && (ch == CH_DOT)) begin
            phase_nxt = PH_PAT_FIRST;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_PAT_FIRST: begin
          if (is_digit) begin
            phase_nxt = ovf ? PH_BAD : PH_PAT;
            patch_nxt = mul10[W-1:0];
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_PAT: begin
          if (is_digit) begin
            phase_nxt = ovf ? PH_BAD : PH_PAT;
            patch_nxt = mul10[W-1:0];
          end else begin
            pre_nxt   = (ch != CH_PLUS);
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      major_r <= '0;
      minor_r <= '0;
      patch_r <= '0;
      pre_r   <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      patch_r <= patch_nxt;
      pre_r   <= pre_nxt;
    end
  end

  assign stat.ref_end  = go && is_nul && (func == FUNC_REF);
  assign stat.cand_end = go && is_nul && (func == FUNC_CAND);
  assign stat.valid    = valid;
  assign stat.pre      = valid && pre_r;
  assign major = major_r;
  assign minor = minor_r;
  assign patch = patch_r;

  // every string end restarts the parse from a clean state
  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    go && is_nul |=> (phase_r == PH_START) && !pre_r && (major_r == '0))
    else $error("parser did not restart after string end");

endmodule

/* rtl/vsc_ref_cmp.sv */
// Held reference version and the candidate-versus-reference comparison.
// Depends on vsc_pkg.
module vsc_ref_cmp #(
  parameter int unsigned COMPONENT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vsc_pkg::parse_stat_t      stat,
  input  logic [COMPONENT_BITS-1:0] major,
  input  logic [COMPONENT_BITS-1:0] minor,
  input  logic [COMPONENT_BITS-1:0] patch,
  output logic [3:0]                result   // newer, ref valid, cand valid, cand pre
);
  import vsc_pkg::*;

  logic [COMPONENT_BITS-1:0] held_major_r, held_minor_r, held_patch_r;
  logic                      held_pre_r, held_valid_r;
  logic                      newer;

  // payload needs no reset: it only matters while held_valid_r is set
  always_ff @(posedge clk) begin
    if (stat.ref_end) begin
      held_major_r <= major;
      held_minor_r <= minor;
      held_patch_r <= patch;
      held_pre_r   <= stat.pre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (stat.ref_end) begin
      held_valid_r <= stat.valid;
    end
  end

  always_comb begin
    if (!stat.valid || !held_valid_r) begin
      newer = 1'b0;
    end else if (major != held_major_r) begin
      newer = major > held_major_r;
    end else if (minor != held_minor_r) begin
      newer = minor > held_minor_r;
    end else if (patch != held_patch_r) begin
      newer = patch > held_patch_r;
    end else begin
      newer = held_pre_r && !stat.pre;
    end
  end

  assign result = {stat.pre, stat.valid, held_valid_r, newer};

  a_ref_load: assert property (@(posedge clk) disable iff (!rst_n)
    stat.ref_end |=> (held_valid_r == $past(stat.valid)))
    else $error("reference validity not captured");

endmodule
